// File: rtl/core/wcta_pkg.sv
// Shared types and constants for the working-calendar time arithmetic block.
// Depends on nothing; imported by wcta_ctrl, wcta_dp and the top level.
`timescale 1ns / 1ps

package wcta_pkg;

  // Default table depth and reset value of the snap threshold
  localparam int          MAX_INTERVALS_DEF = 32;
  localparam logic [19:0] SNAP_THR_RESET    = 20'd600;

  // Operation codes carried by an input item
  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_APPEND     = 3'd1,
    OP_ADD        = 3'd2,
    OP_DIFF       = 3'd3,
    OP_OVERLAP    = 3'd4,
    OP_SNAP_END   = 3'd5,
    OP_SNAP_START = 3'd6
  } op_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_FIN  = 2'd2
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic walk;
    logic out_load;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic walk_done;
  } dp_sts_t;

endpackage

// File: rtl/core/wcta_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; used for the inactivity interval table.
`timescale 1ns / 1ps

module wcta_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/wcta_ctrl.sv
// Controller state machine: sequences load, table walk and result delivery.
// Depends on wcta_pkg for the state, command and status types.
`timescale 1ns / 1ps

module wcta_ctrl
  import wcta_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hold the finished item until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop once taken
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/wcta_dp.sv
// Datapath: interval table, walk registers, per-entry step logic and result register.
// Depends on wcta_pkg and wcta_ram; driven by commands from wcta_ctrl.
`timescale 1ns / 1ps

module wcta_dp
  import wcta_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd,
  output dp_sts_t            sts,
  input  logic [2:0]         in_operation,
  input  logic [31:0]        in_time_a,
  input  logic [31:0]        in_time_b,
  input  logic signed [31:0] in_duration,
  input  logic               cfg_wr_en,
  input  logic [19:0]        cfg_wr_data,
  output logic [32:0]        out_result_time,
  output logic signed [32:0] out_result_span,
  output logic               out_overlap_found,
  output logic               out_status
);

  localparam int AW  = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
  localparam int CW  = $clog2(MAX_INTERVALS + 1);
  localparam int ACW = 34 + CW;

  // Walk and result registers
  op_t                   op_r, op_nxt;
  logic [CW-1:0]         idx_r, idx_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic                  loop_r, loop_nxt;
  logic                  fin_now_r, fin_now_nxt;
  logic [31:0]           lo_r, lo_nxt;
  logic [31:0]           hi_r, hi_nxt;
  logic [31:0]           lim_r, lim_nxt;
  logic                  inv_r, inv_nxt;
  logic [31:0]           ini_r, ini_nxt;
  logic signed [ACW-1:0] rem_r, rem_nxt;
  logic [32:0]           fin_r, fin_nxt;
  logic signed [ACW-1:0] nv_r, nv_nxt;
  logic                  found_r, found_nxt;
  logic                  status_r, status_nxt;
  logic [19:0]           thr_r;
  logic [32:0]           res_time_r;
  logic signed [32:0]    res_span_r;
  logic                  res_ovl_r;
  logic                  res_st_r;

  // Table access
  logic                  wr_en;
  logic [63:0]           rd_data;
  logic [31:0]           ent_s, ent_e;
  logic                  end_tab;
  logic                  full;
  logic                  swap;
  logic                  dur_pos;
  logic [CW-1:0]         idx_inc;
  logic signed [ACW-1:0] rem_step;
  logic [31:0]           ov_hi, ov_lo;
  logic signed [32:0]    ov_len;
  logic                  snap_hit;
  logic                  walk_done;

  // Result shaping
  logic signed [ACW-1:0] tsum;
  logic [32:0]           tclamp;
  logic signed [ACW:0]   lim_ext, nv_ext, dsum;
  logic signed [32:0]    dclamp;

  wcta_ram #(
    .WIDTH (64),
    .DEPTH (MAX_INTERVALS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data ({in_time_a, in_time_b}),
    .rd_addr (idx_nxt[AW-1:0]),
    .rd_data (rd_data)
  );

  assign ent_s    = rd_data[63:32];
  assign ent_e    = rd_data[31:0];
  assign end_tab  = (idx_r >= count_r);
  assign full     = (count_r >= CW'(MAX_INTERVALS));
  assign swap     = (in_time_a < in_time_b);
  assign dur_pos  = !in_duration[31] && (in_duration != 32'sd0);
  assign idx_inc  = idx_r + CW'(1);
  assign rem_step = rem_r - $signed({{(ACW-32){1'b0}}, ent_s})
                          + $signed({{(ACW-32){1'b0}}, ini_r});
  assign ov_hi    = (ent_e < hi_r) ? ent_e : hi_r;
  assign ov_lo    = (ent_s > lo_r) ? ent_s : lo_r;
  // A reversed interval gives a negative overlap length
  assign ov_len   = $signed({1'b0, ov_hi}) - $signed({1'b0, ov_lo});
  assign snap_hit = (op_r == OP_SNAP_START) ? (ent_s >= ini_r) : (ent_s > ini_r);
  assign wr_en    = cmd.load && (op_t'(in_operation) == OP_APPEND) && !full;

  // Load an item, or advance the walk by one table entry
  always_comb begin
    op_nxt      = op_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    loop_nxt    = loop_r;
    fin_now_nxt = fin_now_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    lim_nxt     = lim_r;
    inv_nxt     = inv_r;
    ini_nxt     = ini_r;
    rem_nxt     = rem_r;
    fin_nxt     = fin_r;
    nv_nxt      = nv_r;
    found_nxt   = found_r;
    status_nxt  = status_r;
    walk_done   = 1'b0;

    if (cmd.load) begin
      op_nxt      = op_t'(in_operation);
      idx_nxt     = '0;
      loop_nxt    = 1'b0;
      fin_now_nxt = 1'b0;
      found_nxt   = 1'b0;
      status_nxt  = 1'b0;
      nv_nxt      = '0;
      ini_nxt     = in_time_a;
      rem_nxt     = '0;
      fin_nxt     = {1'b0, in_time_a} + {1'b0, in_duration[31:0]};
      inv_nxt     = swap;
      lim_nxt     = swap ? (in_time_b - in_time_a) : (in_time_a - in_time_b);
      // Difference walks in ascending order; the query takes its span as given
      if ((op_t'(in_operation) == OP_DIFF) && !swap) begin
        lo_nxt = in_time_b;
        hi_nxt = in_time_a;
      end else begin
        lo_nxt = in_time_a;
        hi_nxt = in_time_b;
      end
      case (op_t'(in_operation))
        OP_CLEAR: begin
          count_nxt   = '0;
          fin_now_nxt = 1'b1;
        end
        OP_APPEND: begin
          if (full) begin
            status_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CW'(1);
          end
          fin_now_nxt = 1'b1;
        end
        OP_ADD: begin
          rem_nxt     = dur_pos ? ACW'(in_duration) : '0;
          fin_now_nxt = !dur_pos;
        end
        OP_DIFF, OP_OVERLAP, OP_SNAP_END, OP_SNAP_START: begin
          fin_now_nxt = 1'b0;
        end
        default: begin
          fin_now_nxt = 1'b1;
        end
      endcase
    end else if (cmd.walk) begin
      if (fin_now_r || end_tab) begin
        walk_done = 1'b1;
      end else begin
        case (op_r)
          OP_ADD: begin
            if (!loop_r) begin
              // Find the first interval ending after the base
              if (ent_e > ini_r) begin
                if ({1'b0, ent_s} >= fin_r) begin
                  walk_done = 1'b1;
                end else if (ini_r >= ent_s) begin
                  ini_nxt  = ent_e;
                  idx_nxt  = idx_inc;
                  loop_nxt = 1'b1;
                end else begin
                  loop_nxt = 1'b1;
                end
              end else begin
                idx_nxt = idx_inc;
              end
            end else begin
              // Spend working time up to each interval start
              rem_nxt = rem_step;
              if (rem_step[ACW-1] || (rem_step == '0)) begin
                ini_nxt   = ent_s;
                walk_done = 1'b1;
              end else begin
                ini_nxt = ent_e;
                idx_nxt = idx_inc;
              end
            end
          end
          OP_DIFF: begin
            if ((ent_e > lo_r) && (ent_s < hi_r)) begin
              nv_nxt = nv_r + $signed({{(ACW-33){ov_len[32]}}, ov_len});
            end
            if (ent_s > hi_r) begin
              walk_done = 1'b1;
            end else begin
              idx_nxt = idx_inc;
            end
          end
          OP_OVERLAP: begin
            if (ent_e <= lo_r) begin
              idx_nxt = idx_inc;
            end else begin
              found_nxt = (ent_s < hi_r);
              walk_done = 1'b1;
            end
          end
          OP_SNAP_END, OP_SNAP_START: begin
            if (snap_hit) begin
              walk_done = 1'b1;
              if ((ent_s - ini_r) < {12'd0, thr_r}) begin
                ini_nxt = (op_r == OP_SNAP_START) ? ent_e : ent_s;
              end
            end else begin
              idx_nxt = idx_inc;
            end
          end
          default: begin
            walk_done = 1'b1;
          end
        endcase
      end
    end
  end

  assign sts.walk_done = walk_done;

  // Saturate the timestamp to 0 .. 2^33-1
  assign tsum = $signed({{(ACW-32){1'b0}}, ini_r}) + rem_r;
  always_comb begin
    if (tsum[ACW-1]) begin
      tclamp = '0;
    end else if (tsum > $signed({{(ACW-33){1'b0}}, {33{1'b1}}})) begin
      tclamp = '1;
    end else begin
      tclamp = tsum[32:0];
    end
  end

  // Signed span with the sign restored, saturated to +-(2^32-1)
  assign lim_ext = $signed({{(ACW-31){1'b0}}, lim_r});
  assign nv_ext  = $signed({nv_r[ACW-1], nv_r});
  assign dsum    = inv_r ? (nv_ext - lim_ext) : (lim_ext - nv_ext);
  always_comb begin
    if (dsum > $signed({{(ACW-31){1'b0}}, 32'hFFFF_FFFF})) begin
      dclamp = 33'sh0_FFFF_FFFF;
    end else if (dsum < -$signed({{(ACW-31){1'b0}}, 32'hFFFF_FFFF})) begin
      dclamp = 33'sh1_0000_0001;
    end else begin
      dclamp = dsum[32:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      thr_r   <= SNAP_THR_RESET;
    end else begin
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    idx_r     <= idx_nxt;
    loop_r    <= loop_nxt;
    fin_now_r <= fin_now_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    lim_r     <= lim_nxt;
    inv_r     <= inv_nxt;
    ini_r     <= ini_nxt;
    rem_r     <= rem_nxt;
    fin_r     <= fin_nxt;
    nv_r      <= nv_nxt;
    found_r   <= found_nxt;
    status_r  <= status_nxt;
  end

  // Result register: load a finished item, hold while stalled
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_time_r <= ((op_r == OP_ADD) || (op_r == OP_SNAP_END) || (op_r == OP_SNAP_START))
                    ? tclamp : '0;
      res_span_r <= (op_r == OP_DIFF) ? dclamp : '0;
      res_ovl_r  <= (op_r == OP_OVERLAP) && found_r;
      res_st_r   <= status_r;
    end
  end

  assign out_result_time   = res_time_r;
  assign out_result_span   = res_span_r;
  assign out_overlap_found = res_ovl_r;
  assign out_status        = res_st_r;

endmodule

// File: rtl/core/working_calendar_time_arith.sv
// Working-calendar time arithmetic over a table of inactivity intervals.
// Depends on wcta_pkg, wcta_ctrl and wcta_dp.
//
// Input channel (in_valid / in_stall): one item carries an operation code and
// its operands. Clear and append update the interval table; add, difference,
// overlap query and the two snaps walk the table in order. in_stall is high
// while an item is in work. Result channel (out_valid / out_stall): exactly
// one result item per input item, held in an output register.
// Clear, append, unused codes and non-positive add do not walk the table;
// the other operations walk it, reading one entry per cycle from a
// registered-read RAM (the add can revisit one entry once). A new item is
// accepted in the cycle after the result is loaded, so the block takes no
// new item before it is through with the last one.
// When the receiver stalls, the result waits in the output register; the next
// item is still accepted and worked, and its result holds until the register
// frees. Reset (rst_n low, synchronous) empties the table, sets the snap
// threshold to 600 s and drops out_valid; cfg_wr_en writes the threshold.
`timescale 1ns / 1ps

module working_calendar_time_arith
  import wcta_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_operation,
  input  logic [31:0]        in_time_a,
  input  logic [31:0]        in_time_b,
  input  logic signed [31:0] in_duration,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [32:0]        out_result_time,
  output logic signed [32:0] out_result_span,
  output logic               out_overlap_found,
  output logic               out_status,
  input  logic               cfg_wr_en,
  input  logic [19:0]        cfg_wr_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  wcta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  wcta_dp #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_operation      (in_operation),
    .in_time_a         (in_time_a),
    .in_time_b         (in_time_b),
    .in_duration       (in_duration),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_result_time   (out_result_time),
    .out_result_span   (out_result_span),
    .out_overlap_found (out_overlap_found),
    .out_status        (out_status)
  );

endmodule
